>>> hdl/cdt_pkg.sv
// Shared types and constants for the chessboard distance transform core.
`timescale 1ns / 1ps

package cdt_pkg;

    localparam int MAX_ROWS_DEF   = 256;
    localparam int MAX_COLS_DEF   = 256;
    localparam int DIST_WIDTH_DEF = 8;

    localparam int KIND_W      = 2;
    localparam int COORD_W     = 8;
    localparam int VALUE_W     = 8;
    localparam int CFG_W       = 9;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_W-1:0] COUNT_RESET = 9'd256;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = 2'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE   = 2'd0,
        KIND_COMPUTE = 2'd1,
        KIND_READ    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FWD,
        ST_BWD,
        ST_DONE
    } state_t;

endpackage

>>> hdl/chessboard_distance_transform_core.sv
// Top level of the chessboard distance transform: frame store, pass sequencer and handshakes.
//
// Write and read items are taken one per cycle while the core is idle and no read result waits
// on a stalled output; a read result passes from the frame store's read register into the output
// register. A compute item runs a forward and then a backward raster pass over the active rows x
// cols area. The single read port of the frame store takes each pixel per pass in steps, one read
// of the pixel and four of its neighbours, then the write back of the updated distance.
// The frame store is not cleared after reset: every pixel inside the active area must be written
// before a compute, and every pixel read must have been written.
`timescale 1ns / 1ps

module chessboard_distance_transform_core
    import cdt_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [KIND_W-1:0]      kind,
    input  logic [COORD_W-1:0]     row,
    input  logic [COORD_W-1:0]     col,
    input  logic                   foreground,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_W-1:0]     value,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CLW   = $clog2(MAX_COLS);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = DIST_WIDTH;
    localparam int EXT_W = (DW > VALUE_W) ? DW : VALUE_W;

    localparam logic [DW-1:0] DIST_MAX = '1;

    localparam logic [2:0] STEP_CENTER = 3'd0;
    localparam logic [2:0] STEP_N1     = 3'd1;
    localparam logic [2:0] STEP_N2     = 3'd2;
    localparam logic [2:0] STEP_N3     = 3'd3;
    localparam logic [2:0] STEP_N4     = 3'd4;
    localparam logic [2:0] STEP_WRITE  = 3'd5;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CLW-1:0] c);
        return AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    state_t state_reg, state_next;
    logic [2:0]         step_reg;
    logic [CFG_W-1:0]   row_count_reg;
    logic [CFG_W-1:0]   col_count_reg;
    logic [RW-1:0]      r_reg;
    logic [CLW-1:0]     c_reg;
    logic [RW-1:0]      last_row_reg;
    logic [CLW-1:0]     last_col_reg;
    logic [DW-1:0]      center_reg;
    logic [DW-1:0]      min_reg;
    logic               nb_ok_reg;
    logic [DW-1:0]      best_reg;
    logic [VALUE_W-1:0] max_reg;
    logic               pend_reg;
    logic               pend_zero_reg;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] value_reg;

    kind_t          in_kind;
    logic           accept;
    logic           in_store;
    logic [AW-1:0]  in_addr;
    logic [AW-1:0]  center_addr;
    logic [AW-1:0]  nb_addr;
    logic [RW-1:0]  nb_row;
    logic [CLW-1:0] nb_col;
    logic           up, dn, lt, rt;
    logic           nb_ok;
    logic           computing;
    logic           fwd_last;
    logic           bwd_last;
    logic [RW-1:0]  last_row_next;
    logic [CLW-1:0] last_col_next;
    logic [DW-1:0]  rd_masked;
    logic [DW-1:0]  min_all;
    logic [DW-1:0]  inc_val;
    logic [DW-1:0]  new_val;
    logic [DW-1:0]  px_val;
    logic [DW-1:0]  best_next;
    logic [EXT_W-1:0] rd_ext;
    logic [EXT_W-1:0] best_ext;
    logic           p_move;
    logic           done_load;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [DW-1:0]  ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [DW-1:0]  ram_rdata;

    cdt_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_kind     = kind_t'(kind);
    assign accept      = in_valid && in_ready;
    assign in_store    = (32'(row) < 32'(MAX_ROWS)) && (32'(col) < 32'(MAX_COLS));
    assign in_addr     = cell_addr(RW'(row), CLW'(col));
    assign center_addr = cell_addr(r_reg, c_reg);
    assign computing   = (state_reg == ST_FWD) || (state_reg == ST_BWD);
    assign fwd_last    = (r_reg == last_row_reg) && (c_reg == last_col_reg);
    assign bwd_last    = (r_reg == '0) && (c_reg == '0);
    assign p_move      = pend_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        if (row_count_reg == '0)
        begin
            last_row_next = '0;
        end
        else if (32'(row_count_reg) > 32'(MAX_ROWS))
        begin
            last_row_next = RW'(MAX_ROWS - 1);
        end
        else
        begin
            last_row_next = RW'(row_count_reg - CFG_W'(1));
        end
        if (col_count_reg == '0)
        begin
            last_col_next = '0;
        end
        else if (32'(col_count_reg) > 32'(MAX_COLS))
        begin
            last_col_next = CLW'(MAX_COLS - 1);
        end
        else
        begin
            last_col_next = CLW'(col_count_reg - CFG_W'(1));
        end
    end

    always_comb
    begin
        up = 1'b0;
        dn = 1'b0;
        lt = 1'b0;
        rt = 1'b0;
        if (state_reg == ST_BWD)
        begin
            case (step_reg)
                STEP_N1: rt = 1'b1;
                STEP_N2:
                begin
                    dn = 1'b1;
                    lt = 1'b1;
                end
                STEP_N3: dn = 1'b1;
                STEP_N4:
                begin
                    dn = 1'b1;
                    rt = 1'b1;
                end
                default: ;
            endcase
        end
        else
        begin
            case (step_reg)
                STEP_N1:
                begin
                    up = 1'b1;
                    lt = 1'b1;
                end
                STEP_N2: up = 1'b1;
                STEP_N3:
                begin
                    up = 1'b1;
                    rt = 1'b1;
                end
                STEP_N4: lt = 1'b1;
                default: ;
            endcase
        end
        nb_row = up ? r_reg - RW'(1) : (dn ? r_reg + RW'(1) : r_reg);
        nb_col = lt ? c_reg - CLW'(1) : (rt ? c_reg + CLW'(1) : c_reg);
        nb_ok  = !(up && r_reg == '0) && !(dn && r_reg == last_row_reg)
              && !(lt && c_reg == '0) && !(rt && c_reg == last_col_reg);
        nb_addr = nb_ok ? cell_addr(nb_row, nb_col) : center_addr;
    end

    always_comb
    begin
        rd_masked = nb_ok_reg ? ram_rdata : '0;
        min_all   = (rd_masked < min_reg) ? rd_masked : min_reg;
        inc_val   = (min_all == DIST_MAX) ? DIST_MAX : min_all + DW'(1);
        if (state_reg == ST_BWD)
        begin
            new_val = (inc_val < center_reg) ? inc_val : center_reg;
        end
        else
        begin
            new_val = inc_val;
        end
        px_val    = (center_reg != '0) ? new_val : center_reg;
        best_next = (px_val > best_reg) ? px_val : best_reg;
        rd_ext    = EXT_W'(ram_rdata);
        best_ext  = EXT_W'(best_next);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_kind == KIND_COMPUTE)
                begin
                    state_next = ST_FWD;
                end
            end
            ST_FWD:
            begin
                if (step_reg == STEP_WRITE && fwd_last)
                begin
                    state_next = ST_BWD;
                end
            end
            ST_BWD:
            begin
                if (step_reg == STEP_WRITE && bwd_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        done_load = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = in_addr;
        ram_wdata = DW'(foreground);
        ram_re    = 1'b0;
        ram_raddr = in_addr;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !pend_reg || p_move;
                ram_we   = accept && in_kind == KIND_WRITE && in_store;
                ram_re   = accept && in_kind == KIND_READ && in_store;
            end
            ST_FWD, ST_BWD:
            begin
                ram_re    = step_reg != STEP_WRITE;
                ram_raddr = (step_reg == STEP_CENTER) ? center_addr : nb_addr;
                ram_we    = step_reg == STEP_WRITE && center_reg != '0;
                ram_waddr = center_addr;
                ram_wdata = new_val;
            end
            ST_DONE:
            begin
                done_load = !out_valid_reg || out_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_CENTER;
            row_count_reg <= COUNT_RESET;
            col_count_reg <= COUNT_RESET;
            max_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (computing && step_reg != STEP_WRITE)
            begin
                step_reg <= step_reg + 3'd1;
            end
            else
            begin
                step_reg <= STEP_CENTER;
            end
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    REG_ROW_COUNT: row_count_reg <= cfg_data;
                    REG_COL_COUNT: col_count_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_BWD && step_reg == STEP_WRITE && bwd_last)
            begin
                max_reg <= best_ext[VALUE_W-1:0];
            end
            if (accept && in_kind == KIND_READ)
            begin
                pend_reg <= 1'b1;
            end
            else if (p_move)
            begin
                pend_reg <= 1'b0;
            end
            if (p_move || done_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        nb_ok_reg <= nb_ok;
        if (accept && in_kind == KIND_READ)
        begin
            pend_zero_reg <= !in_store;
        end
        if (p_move)
        begin
            value_reg <= pend_zero_reg ? '0 : rd_ext[VALUE_W-1:0];
        end
        else if (done_load)
        begin
            value_reg <= max_reg;
        end
        if (accept && in_kind == KIND_COMPUTE)
        begin
            r_reg        <= '0;
            c_reg        <= '0;
            last_row_reg <= last_row_next;
            last_col_reg <= last_col_next;
        end
        else if (state_reg == ST_FWD && step_reg == STEP_WRITE)
        begin
            if (fwd_last)
            begin
                r_reg    <= last_row_reg;
                c_reg    <= last_col_reg;
                best_reg <= '0;
            end
            else if (c_reg == last_col_reg)
            begin
                c_reg <= '0;
                r_reg <= r_reg + RW'(1);
            end
            else
            begin
                c_reg <= c_reg + CLW'(1);
            end
        end
        else if (state_reg == ST_BWD && step_reg == STEP_WRITE)
        begin
            best_reg <= best_next;
            if (c_reg == '0)
            begin
                c_reg <= last_col_reg;
                r_reg <= r_reg - RW'(1);
            end
            else
            begin
                c_reg <= c_reg - CLW'(1);
            end
        end
        if (computing && step_reg == STEP_N1)
        begin
            center_reg <= ram_rdata;
        end
        if (computing && step_reg == STEP_N2)
        begin
            min_reg <= rd_masked;
        end
        else if (computing && (step_reg == STEP_N3 || step_reg == STEP_N4))
        begin
            min_reg <= min_all;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_WRITE)
        else $error("pixel step counter out of range");

    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        computing |-> (r_reg <= last_row_reg && c_reg <= last_col_reg))
        else $error("raster position outside the active area");

    a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (computing && ram_we) |-> (step_reg == STEP_WRITE && !ram_re))
        else $error("frame store written outside the write-back slot");

    a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && out_valid_reg && !out_ready) |=> pend_reg)
        else $error("pending read result dropped while output stalled");

    a_one_loader: assert property (@(posedge clk) disable iff (!rst_n)
        !(done_load && p_move))
        else $error("output register loaded from two sources");

endmodule

>>> hdl/cdt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module cdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> tb/sv/chessboard_distance_transform_core_test.sv
// Self-checking bench for the chessboard distance transform core against a behavioural frame model.
`timescale 1ns / 1ps

module chessboard_distance_transform_core_test;
    import cdt_pkg::*;

    localparam int STORE_DEPTH      = MAX_ROWS_DEF * MAX_COLS_DEF;
    localparam int STIM_TARGET      = 1350;
    localparam int BURST_READS      = 60;
    localparam int LONG_HOLD_CYCLES = 250;
    localparam int SETTLE_CYCLES    = 8;
    localparam int TAIL_CYCLES      = 24;
    localparam int CYCLE_LIMIT      = 1500000;

    localparam logic [KIND_W-1:0]      KIND_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    typedef logic [DIST_WIDTH_DEF-1:0] dist_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               foreground;
    } pixel_op_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   in_valid     = 1'b0;
    logic                   in_ready;
    logic [KIND_W-1:0]      kind         = '0;
    logic [COORD_W-1:0]     row          = '0;
    logic [COORD_W-1:0]     col          = '0;
    logic                   foreground   = 1'b0;
    logic                   out_valid;
    logic                   out_ready    = 1'b0;
    logic [VALUE_W-1:0]     value;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_W-1:0]       cfg_data     = '0;

    dist_t              frame_model [0:STORE_DEPTH-1];
    bit                 store_written [0:STORE_DEPTH-1];
    int                 written_list [$];
    logic [CFG_W-1:0]   row_count_q = COUNT_RESET;
    logic [CFG_W-1:0]   col_count_q = COUNT_RESET;
    int                 area_rows;
    int                 area_cols;
    bit                 area_filled = 1'b0;

    pixel_op_t          pending_ops [$];
    pixel_op_t          op_on_bus;
    logic [VALUE_W-1:0] expected_values [$];
    logic [VALUE_W-1:0] expected_value;

    bit   no_idle = 1'b0;
    bit   hold_go = 1'b0;
    logic hold_rx = 1'b0;
    int   tx_gap = 0;
    int   rx_gap = 0;

    int queued_count = 0;
    int accepted_count = 0;
    int stim_count = 0;
    int writes_seen = 0;
    int computes_seen = 0;
    int reads_seen = 0;
    int ignored_seen = 0;
    int results_checked = 0;
    int settings_written = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    chessboard_distance_transform_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .row          (row),
        .col          (col),
        .foreground   (foreground),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value        (value),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int effective_count(logic [CFG_W-1:0] data, int limit);
        if (data == '0)
            return 1;
        if (int'(data) > limit)
            return limit;
        return int'(data);
    endfunction

    function automatic dist_t area_pixel(int r, int c, int nr, int nc);
        if (r < 0 || c < 0 || r >= nr || c >= nc)
            return '0;
        return frame_model[r * MAX_COLS_DEF + c];
    endfunction

    function automatic dist_t lesser(dist_t a, dist_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic dist_t bump(dist_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic dist_t run_chessboard_passes();
        int    nr;
        int    nc;
        int    idx;
        dist_t m;
        dist_t v;
        dist_t best;
        nr = effective_count(row_count_q, MAX_ROWS_DEF);
        nc = effective_count(col_count_q, MAX_COLS_DEF);
        best = '0;
        for (int r = 0; r < nr; r++)
        begin
            for (int c = 0; c < nc; c++)
            begin
                idx = r * MAX_COLS_DEF + c;
                if (frame_model[idx] != '0)
                begin
                    m = area_pixel(r - 1, c - 1, nr, nc);
                    m = lesser(m, area_pixel(r - 1, c, nr, nc));
                    m = lesser(m, area_pixel(r - 1, c + 1, nr, nc));
                    m = lesser(m, area_pixel(r, c - 1, nr, nc));
                    frame_model[idx] = bump(m);
                end
            end
        end
        for (int r = nr - 1; r >= 0; r--)
        begin
            for (int c = nc - 1; c >= 0; c--)
            begin
                idx = r * MAX_COLS_DEF + c;
                v = frame_model[idx];
                if (v != '0)
                begin
                    m = area_pixel(r, c + 1, nr, nc);
                    m = lesser(m, area_pixel(r + 1, c - 1, nr, nc));
                    m = lesser(m, area_pixel(r + 1, c, nr, nc));
                    m = lesser(m, area_pixel(r + 1, c + 1, nr, nc));
                    v = lesser(v, bump(m));
                    frame_model[idx] = v;
                end
                if (v > best)
                    best = v;
            end
        end
        return best;
    endfunction

    task automatic apply_to_frame_model(pixel_op_t op);
        int idx;
        idx = int'(op.row) * MAX_COLS_DEF + int'(op.col);
        case (op.kind)
            KIND_WRITE:
            begin
                frame_model[idx] = dist_t'(op.foreground);
                writes_seen++;
            end
            KIND_COMPUTE:
            begin
                expected_values.push_back(run_chessboard_passes());
                computes_seen++;
            end
            KIND_READ:
            begin
                expected_values.push_back(frame_model[idx]);
                reads_seen++;
            end
            default:
                ignored_seen++;
        endcase
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 88)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Driver: hold each item until accepted, then advance after a random gap.
    always @(posedge clk)
    begin : item_driver
        if (in_valid && in_ready)
        begin
            apply_to_frame_model(op_on_bus);
            accepted_count++;
        end
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (tx_gap > 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_ops.size() != 0)
            begin
                op_on_bus = pending_ops.pop_front();
                kind       <= op_on_bus.kind;
                row        <= op_on_bus.row;
                col        <= op_on_bus.col;
                foreground <= op_on_bus.foreground;
                in_valid   <= 1'b1;
                tx_gap = no_idle ? 0 : pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: check each accepted result against the oldest expected value.
    always @(posedge clk)
    begin : result_monitor
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_values.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, got %0d", $time, value);
                mismatch_count++;
            end
            else
            begin
                expected_value = expected_values.pop_front();
                results_checked++;
                if (value !== expected_value)
                begin
                    $display("%0t ns: value mismatch, expected %0d, got %0d",
                             $time, expected_value, value);
                    mismatch_count++;
                end
            end
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_rx)
            out_ready <= 1'b0;
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            rx_gap = (no_idle || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
            out_ready <= (rx_gap == 0);
        end
    end

    initial
    begin : receiver_hold
        wait (hold_go);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout after %0d cycles", $time, CYCLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_op(logic [KIND_W-1:0] k, int r, int c, logic fg);
        pixel_op_t op;
        int        idx;
        op.kind       = k;
        op.row        = r[COORD_W-1:0];
        op.col        = c[COORD_W-1:0];
        op.foreground = fg;
        pending_ops.push_back(op);
        queued_count++;
        if (k != KIND_UNUSED)
            stim_count++;
        idx = int'(op.row) * MAX_COLS_DEF + int'(op.col);
        if (k == KIND_WRITE && !store_written[idx])
        begin
            store_written[idx] = 1'b1;
            written_list.push_back(idx);
        end
    endtask

    task automatic queue_read();
        int idx;
        if (area_filled && $urandom_range(0, 99) < 70)
            idx = $urandom_range(0, area_rows - 1) * MAX_COLS_DEF
                  + $urandom_range(0, area_cols - 1);
        else
            idx = written_list[$urandom_range(0, written_list.size() - 1)];
        queue_op(KIND_READ, idx / MAX_COLS_DEF, idx % MAX_COLS_DEF, 1'($urandom_range(0, 1)));
    endtask

    task automatic queue_noise();
        if ($urandom_range(0, 1) != 0)
            queue_op(KIND_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255),
                     1'($urandom_range(0, 1)));
        else
            queue_op(KIND_WRITE, $urandom_range(0, 255), $urandom_range(0, 255),
                     1'($urandom_range(0, 1)));
    endtask

    // Write every unwritten pixel of the active area, rewrite some of the rest, and queue occasional noise items.
    task automatic fill_area(int rewrite_pct);
        int fg_pct;
        int idx;
        case ($urandom_range(0, 9))
            0:       fg_pct = 0;
            1, 2:    fg_pct = 100;
            default: fg_pct = $urandom_range(40, 95);
        endcase
        for (int r = 0; r < area_rows; r++)
        begin
            for (int c = 0; c < area_cols; c++)
            begin
                idx = r * MAX_COLS_DEF + c;
                if (!store_written[idx] || $urandom_range(0, 99) < rewrite_pct)
                    queue_op(KIND_WRITE, r, c, $urandom_range(0, 99) < fg_pct);
                if ($urandom_range(0, 99) < 4)
                    queue_noise();
            end
        end
        area_filled = 1'b1;
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || expected_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] reg_index, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= reg_index;
        cfg_data     <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (reg_index == REG_ROW_COUNT)
            row_count_q = data;
        else if (reg_index == REG_COL_COUNT)
            col_count_q = data;
        settings_written++;
    endtask

    task automatic set_counts(logic [CFG_W-1:0] rows_data, logic [CFG_W-1:0] cols_data);
        wait_drained();
        write_register(REG_ROW_COUNT, rows_data);
        write_register(REG_COL_COUNT, cols_data);
        area_rows   = effective_count(row_count_q, MAX_ROWS_DEF);
        area_cols   = effective_count(col_count_q, MAX_COLS_DEF);
        area_filled = 1'b0;
        no_idle     = ($urandom_range(0, 4) == 0);
    endtask

    initial
    begin : stimulus
        int shape;
        int frame_no;
        int rows_data;
        int cols_data;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        queue_op(KIND_WRITE, 0, 0, 1'b0);
        queue_op(KIND_WRITE, 255, 255, 1'b1);
        queue_op(KIND_WRITE, 170, 85, 1'b1);
        queue_op(KIND_WRITE, 85, 170, 1'b0);
        queue_op(KIND_UNUSED, 255, 255, 1'b1);
        queue_op(KIND_READ, 0, 0, 1'b1);
        queue_op(KIND_READ, 255, 255, 1'b0);
        queue_op(KIND_READ, 170, 85, 1'b0);
        queue_op(KIND_READ, 85, 170, 1'b1);
        wait_drained();
        write_register(REG_SPARE_A, '1);
        write_register(REG_SPARE_B, 9'h155);

        set_counts(9'd0, 9'd2);
        queue_op(KIND_WRITE, 0, 0, 1'b1);
        queue_op(KIND_WRITE, 0, 1, 1'b1);
        queue_op(KIND_COMPUTE, 0, 0, 1'b0);
        queue_op(KIND_READ, 0, 1, 1'b0);
        queue_op(KIND_COMPUTE, 255, 255, 1'b1);

        set_counts(9'd3, 9'd3);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
                queue_op(KIND_WRITE, r, c, 1'b1);
        end
        area_filled = 1'b1;
        queue_op(KIND_COMPUTE, 0, 0, 1'b0);
        queue_op(KIND_READ, 1, 1, 1'b0);

        // Pause until drained, then flood reads while the receiver holds off.
        wait_drained();
        no_idle = 1'b1;
        hold_go = 1'b1;
        repeat (BURST_READS) queue_read();

        frame_no = 0;
        while (stim_count < STIM_TARGET)
        begin
            if (frame_no == 0)
                set_counts(9'd511, 9'd0);
            else if (frame_no == 1)
                set_counts(9'd1, 9'd256);
            else if (frame_no == 2 || $urandom_range(0, 3) != 0)
            begin
                shape = $urandom_range(0, 99);
                if (shape < 70)
                begin
                    rows_data = $urandom_range(0, 6);
                    cols_data = $urandom_range(0, 6);
                end
                else if (shape < 90)
                begin
                    rows_data = $urandom_range(7, 14);
                    cols_data = $urandom_range(7, 14);
                end
                else if (shape < 95)
                begin
                    rows_data = $urandom_range(0, 1);
                    cols_data = $urandom_range(20, 60);
                end
                else
                begin
                    rows_data = $urandom_range(20, 60);
                    cols_data = $urandom_range(0, 1);
                end
                set_counts(CFG_W'(rows_data), CFG_W'(cols_data));
            end
            fill_area(area_filled ? $urandom_range(0, 30) : $urandom_range(0, 100));
            if ($urandom_range(0, 4) == 0)
                queue_read();
            queue_op(KIND_COMPUTE, $urandom_range(0, 255), $urandom_range(0, 255),
                     1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 6)) queue_read();
            if ($urandom_range(0, 9) == 0)
                queue_op(KIND_COMPUTE, $urandom_range(0, 255), $urandom_range(0, 255),
                         1'($urandom_range(0, 1)));
            frame_no++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d pixel writes, %0d transforms, %0d reads and %0d ignored items",
                 writes_seen, computes_seen, reads_seen, ignored_seen);
        $display("over %0d frames and %0d register writes; %0d results checked, %0d mismatches.",
                 frame_no, settings_written, results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> chessboard_distance_transform_core.f
hdl/cdt_pkg.sv
hdl/cdt_ram.sv
hdl/chessboard_distance_transform_core.sv
tb/sv/chessboard_distance_transform_core_test.sv
